// ----- rtl/bgpc_pkg.sv -----
// Shared types, constants and codes of the bidirectional gate passage counter.
`default_nettype none
package bgpc_pkg;

  localparam int MAX_GATES  = 16;
  localparam int LANE_W     = (MAX_GATES > 1) ? $clog2(MAX_GATES) : 1;
  localparam int GATE_W     = 4;
  localparam int GATE_CMP_W = 8;
  localparam int FUNC_W     = 2;
  localparam int AREA_W     = 24;
  localparam int GCNT_W     = 5;
  localparam int MIN_W      = 16;
  localparam int DAY_W      = 24;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;

  localparam logic [AREA_W-1:0] THRESH_RESET = AREA_W'(200);
  localparam logic [GCNT_W-1:0] GATES_RESET  = GCNT_W'(10);

  localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GATES  = 1'b1;

  localparam logic [FUNC_W-1:0] FN_OBS = 2'd0;
  localparam logic [FUNC_W-1:0] FN_MIN = 2'd1;
  localparam logic [FUNC_W-1:0] FN_DAY = 2'd2;

  // Depth of the small queues between and after the two halves.
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  typedef enum logic [2:0] {
    OP_OBS = 3'd0,
    OP_MIN = 3'd1,
    OP_DAY = 3'd2,
    OP_NOP = 3'd3,
    OP_REJ = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_IN   = 2'd1,
    DIR_OUT  = 2'd2
  } dir_t;

  typedef struct packed {
    op_t               op;
    logic [LANE_W-1:0] lane;
    logic              inner;
    logic              outer;
  } cmd_t;

  typedef struct packed {
    logic             status;
    logic             entered;
    logic             exited;
    logic [MIN_W-1:0] min_in;
    logic [MIN_W-1:0] min_out;
    logic [DAY_W-1:0] day_in;
    logic [DAY_W-1:0] day_out;
  } res_t;

endpackage
`default_nettype wire

// ----- rtl/bgpc_front.sv -----
// Front half: configuration registers, item classification and the command queue.
`default_nettype none
module bgpc_front (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [bgpc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [bgpc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                             in_push,
  output logic                                  in_full,
  input  wire logic [bgpc_pkg::FUNC_W-1:0]      in_func,
  input  wire logic [bgpc_pkg::GATE_W-1:0]      in_gate,
  input  wire logic [bgpc_pkg::AREA_W-1:0]      in_left_area,
  input  wire logic [bgpc_pkg::AREA_W-1:0]      in_right_area,
  output logic                                  cmd_valid,
  input  wire logic                             cmd_pop,
  output bgpc_pkg::cmd_t                        cmd
);
  import bgpc_pkg::*;

  logic [AREA_W-1:0]     thresh_r;
  logic [GCNT_W-1:0]     gcnt_r;
  logic [GATE_CMP_W-1:0] gate_ext;
  logic                  lane_ok;
  cmd_t                  cls;
  cmd_t                  q_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]    wr_ptr_r;
  logic [Q_PTR_W-1:0]    rd_ptr_r;
  logic [Q_CNT_W-1:0]    cnt_r;
  logic [Q_CNT_W-1:0]    cnt_nxt;
  logic                  push;
  logic                  pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RESET;
      gcnt_r   <= GATES_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_THRESH: thresh_r <= cfg_data[AREA_W-1:0];
        CFG_GATES:  gcnt_r   <= cfg_data[GCNT_W-1:0];
        default:    ;
      endcase
    end
  end

  // Classify: range-check the lane and compare both windows to the threshold.
  always_comb begin
    gate_ext  = GATE_CMP_W'(in_gate);
    lane_ok   = (gate_ext < GATE_CMP_W'(gcnt_r)) && (gate_ext < GATE_CMP_W'(MAX_GATES));
    cls.lane  = gate_ext[LANE_W-1:0];
    cls.inner = in_left_area > thresh_r;
    cls.outer = in_right_area > thresh_r;
    case (in_func)
      FN_OBS:  cls.op = lane_ok ? OP_OBS : OP_REJ;
      FN_MIN:  cls.op = OP_MIN;
      FN_DAY:  cls.op = OP_DAY;
      default: cls.op = OP_NOP;
    endcase
  end

  assign in_full   = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rd_ptr_r];
  assign push      = in_push && !in_full;
  assign pop       = cmd_pop && cmd_valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= cls;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= Q_CNT_W'(Q_DEPTH)) else $error("command queue overfilled");
  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + 1'b1) else $error("queue count lost a push");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0 || cnt_r == Q_CNT_W'(Q_DEPTH)) |-> wr_ptr_r == rd_ptr_r)
    else $error("queue pointers disagree with count");

endmodule
`default_nettype wire

// ----- rtl/bgpc_back.sv -----
// Back half: per-lane passage tracking, saturating totals and the result queue.
`default_nettype none
module bgpc_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cmd_valid,
  output logic                               cmd_pop,
  input  wire bgpc_pkg::cmd_t                cmd,
  input  wire logic                          out_pop,
  output logic                               out_empty,
  output bgpc_pkg::res_t                     res
);
  import bgpc_pkg::*;

  dir_t               lane_dir_r [MAX_GATES];
  logic               lane_cr_r  [MAX_GATES];
  logic [MIN_W-1:0]   min_in_r, min_out_r, min_in_nxt, min_out_nxt;
  logic [DAY_W-1:0]   day_in_r, day_out_r, day_in_nxt, day_out_nxt;
  dir_t               cur_dir, lane_dir_nxt;
  logic               cur_cr, lane_cr_nxt;
  res_t               res_nxt;
  logic               go;
  logic               oq_ready;
  res_t               oq_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               opop;

  assign out_empty = (cnt_r == '0);
  assign res       = oq_r[rd_ptr_r];
  assign opop      = out_pop && !out_empty;
  // A full result queue still takes a result in the cycle its head leaves.
  assign oq_ready  = (cnt_r != Q_CNT_W'(Q_DEPTH)) || opop;
  assign go        = cmd_valid && oq_ready;
  assign cmd_pop   = go;

  assign cur_dir = lane_dir_r[cmd.lane];
  assign cur_cr  = lane_cr_r[cmd.lane];

  always_comb begin
    lane_dir_nxt = cur_dir;
    lane_cr_nxt  = cur_cr;
    min_in_nxt   = min_in_r;
    min_out_nxt  = min_out_r;
    day_in_nxt   = day_in_r;
    day_out_nxt  = day_out_r;
    res_nxt      = '0;
    case (cmd.op)
      OP_OBS: begin
        if (!cmd.inner && cmd.outer) lane_dir_nxt = DIR_OUT;
        if (cmd.inner && !cmd.outer) lane_dir_nxt = DIR_IN;
        if (cmd.inner && cmd.outer)  lane_cr_nxt  = 1'b1;
        if (!cmd.inner && !cmd.outer && cur_cr) begin
          if (cur_dir == DIR_IN) begin
            min_in_nxt      = (min_in_r == '1) ? min_in_r : min_in_r + 1'b1;
            day_in_nxt      = (day_in_r == '1) ? day_in_r : day_in_r + 1'b1;
            lane_dir_nxt    = DIR_NONE;
            lane_cr_nxt     = 1'b0;
            res_nxt.entered = 1'b1;
          end else if (cur_dir == DIR_OUT) begin
            min_out_nxt    = (min_out_r == '1) ? min_out_r : min_out_r + 1'b1;
            day_out_nxt    = (day_out_r == '1) ? day_out_r : day_out_r + 1'b1;
            lane_dir_nxt   = DIR_NONE;
            lane_cr_nxt    = 1'b0;
            res_nxt.exited = 1'b1;
          end
        end
      end
      OP_MIN: begin
        min_in_nxt  = '0;
        min_out_nxt = '0;
      end
      OP_DAY: begin
        day_in_nxt  = '0;
        day_out_nxt = '0;
      end
      OP_REJ:  res_nxt.status = 1'b1;
      default: ;
    endcase
    // Observations report the totals after their update, ticks before the clear.
    if (cmd.op == OP_MIN || cmd.op == OP_DAY) begin
      res_nxt.min_in  = min_in_r;
      res_nxt.min_out = min_out_r;
      res_nxt.day_in  = day_in_r;
      res_nxt.day_out = day_out_r;
    end else begin
      res_nxt.min_in  = min_in_nxt;
      res_nxt.min_out = min_out_nxt;
      res_nxt.day_in  = day_in_nxt;
      res_nxt.day_out = day_out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_GATES; i++) begin
        lane_dir_r[i] <= DIR_NONE;
        lane_cr_r[i]  <= 1'b0;
      end
      min_in_r  <= '0;
      min_out_r <= '0;
      day_in_r  <= '0;
      day_out_r <= '0;
    end else if (go) begin
      if (cmd.op == OP_OBS) begin
        lane_dir_r[cmd.lane] <= lane_dir_nxt;
        lane_cr_r[cmd.lane]  <= lane_cr_nxt;
      end
      min_in_r  <= min_in_nxt;
      min_out_r <= min_out_nxt;
      day_in_r  <= day_in_nxt;
      day_out_r <= day_out_nxt;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (go && !opop) cnt_nxt = cnt_r + 1'b1;
    if (opop && !go) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (go)   wr_ptr_r <= wr_ptr_r + 1'b1;
      if (opop) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go) oq_r[wr_ptr_r] <= res_nxt;
  end

  a_one_way: assert property (@(posedge clk) disable iff (!rst_n)
    go |-> !(res_nxt.entered && res_nxt.exited)) else $error("entry and exit at once");
  a_rej_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (go && res_nxt.status) |-> !res_nxt.entered && !res_nxt.exited)
    else $error("rejected lane counted a passage");
  a_min_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (go && cmd.op == OP_MIN) |=> min_in_r == '0 && min_out_r == '0)
    else $error("minute tick left totals");
  a_entry_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (go && res_nxt.entered) |=> day_in_r != '0) else $error("entry not in day total");
  a_oq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= Q_CNT_W'(Q_DEPTH)) else $error("result queue overfilled");

endmodule
`default_nettype wire

// ----- rtl/bidirectional_gate_passage_counter.sv -----
// Top level of the bidirectional gate passage counter.
//
//  channel   direction  handshake          payload
//  in_*      input      in_push / in_full   in_func, in_gate, in_left_area, in_right_area
//  out_*     output     out_pop / out_empty out_status, out_entered, out_exited, totals
//  cfg_*     input      cfg_we              cfg_index, cfg_data
//
// One item per clock sustained while the receiver keeps popping results; each item
// passes the front queue register, then the result queue register, before it leaves.
// The lane state and totals update in the back half, which sets the rate.
// rst_n is synchronous: it clears lane state, totals, queues and loads register defaults.
// Either side may stall: a two-entry queue sits between the halves and another
// in front of the result ports, so a held result blocks new transactions only once
// four transactions are waiting inside the block.
`default_nettype none
module bidirectional_gate_passage_counter (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [bgpc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [bgpc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                             in_push,
  output logic                                  in_full,
  input  wire logic [bgpc_pkg::FUNC_W-1:0]      in_func,
  input  wire logic [bgpc_pkg::GATE_W-1:0]      in_gate,
  input  wire logic [bgpc_pkg::AREA_W-1:0]      in_left_area,
  input  wire logic [bgpc_pkg::AREA_W-1:0]      in_right_area,
  input  wire logic                             out_pop,
  output logic                                  out_empty,
  output logic                                  out_status,
  output logic                                  out_entered,
  output logic                                  out_exited,
  output logic [bgpc_pkg::MIN_W-1:0]            out_minute_entries,
  output logic [bgpc_pkg::MIN_W-1:0]            out_minute_exits,
  output logic [bgpc_pkg::DAY_W-1:0]            out_day_entries,
  output logic [bgpc_pkg::DAY_W-1:0]            out_day_exits
);
  import bgpc_pkg::*;

  // Classified commands pass from front to back through the front queue.
  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;
  res_t res;

  bgpc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_func      (in_func),
    .in_gate      (in_gate),
    .in_left_area (in_left_area),
    .in_right_area(in_right_area),
    .cmd_valid    (cmd_valid),
    .cmd_pop      (cmd_pop),
    .cmd          (cmd)
  );

  // Back half pops a command whenever its result queue can take the result.
  bgpc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_valid(cmd_valid),
    .cmd_pop  (cmd_pop),
    .cmd      (cmd),
    .out_pop  (out_pop),
    .out_empty(out_empty),
    .res      (res)
  );

  // Unpack the head result onto the individual result ports.
  assign out_status         = res.status;
  assign out_entered        = res.entered;
  assign out_exited         = res.exited;
  assign out_minute_entries = res.min_in;
  assign out_minute_exits   = res.min_out;
  assign out_day_entries    = res.day_in;
  assign out_day_exits      = res.day_out;

endmodule
`default_nettype wire

// ----- tb/tb_bidirectional_gate_passage_counter.sv -----
// Self-checking testbench for the bidirectional gate passage counter: crossings, ticks, rejects.
module tb_bidirectional_gate_passage_counter;
  timeunit 1ns;
  timeprecision 1ps;
  import bgpc_pkg::*;

  // Function code that the block leaves unused; it must report totals and change nothing.
  localparam logic [FUNC_W-1:0] FN_SPARE = 2'd3;
  localparam logic [AREA_W-1:0] AREA_MAX = '1;
  localparam logic [MIN_W-1:0]  MIN_MAX  = '1;
  localparam logic [DAY_W-1:0]  DAY_MAX  = '1;
  // Cap on printed mismatches so that a broken build cannot flood the log.
  localparam int unsigned REPORT_CAP = 100;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [GATE_W-1:0] gate;
    logic [AREA_W-1:0] left_area;
    logic [AREA_W-1:0] right_area;
  } frame_t;

  // Every input of the block starts at a known value.
  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_push   = 1'b0;
  logic                  in_full;
  logic [FUNC_W-1:0]     in_func       = '0;
  logic [GATE_W-1:0]     in_gate       = '0;
  logic [AREA_W-1:0]     in_left_area  = '0;
  logic [AREA_W-1:0]     in_right_area = '0;
  logic                  out_pop   = 1'b0;
  logic                  out_empty;
  logic                  out_status;
  logic                  out_entered;
  logic                  out_exited;
  logic [MIN_W-1:0]      out_minute_entries;
  logic [MIN_W-1:0]      out_minute_exits;
  logic [DAY_W-1:0]      out_day_entries;
  logic [DAY_W-1:0]      out_day_exits;

  bidirectional_gate_passage_counter dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_func           (in_func),
    .in_gate           (in_gate),
    .in_left_area      (in_left_area),
    .in_right_area     (in_right_area),
    .out_pop           (out_pop),
    .out_empty         (out_empty),
    .out_status        (out_status),
    .out_entered       (out_entered),
    .out_exited        (out_exited),
    .out_minute_entries(out_minute_entries),
    .out_minute_exits  (out_minute_exits),
    .out_day_entries   (out_day_entries),
    .out_day_exits     (out_day_exits)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Passage predictor: own copy of registers, lane memory and totals.
  // ---------------------------------------------------------------------------
  logic [AREA_W-1:0] thresh_m = THRESH_RESET;
  logic [GCNT_W-1:0] gates_m  = GATES_RESET;
  dir_t              lane_dir     [MAX_GATES] = '{default: DIR_NONE};
  logic              lane_crossed [MAX_GATES] = '{default: 1'b0};
  logic [MIN_W-1:0]  min_in_m  = '0;
  logic [MIN_W-1:0]  min_out_m = '0;
  logic [DAY_W-1:0]  day_in_m  = '0;
  logic [DAY_W-1:0]  day_out_m = '0;

  // Advance the predicted lane state by one frame and return the result it produces.
  function automatic res_t tally_frame(frame_t f);
    res_t r;
    logic occ_in;
    logic occ_out;
    r = '0;
    if (f.func == FN_OBS) begin
      if (f.gate >= gates_m) begin
        // Lane beyond the configured count: flag it and touch nothing.
        r.status = 1'b1;
      end else begin
        occ_in  = f.left_area > thresh_m;
        occ_out = f.right_area > thresh_m;
        if (!occ_in && occ_out) lane_dir[f.gate] = DIR_OUT;
        if (occ_in && !occ_out) lane_dir[f.gate] = DIR_IN;
        // Both windows busy: mark the crossing, keep the direction.
        if (occ_in && occ_out) lane_crossed[f.gate] = 1'b1;
        // Both clear after a crossing: count only when the direction is known.
        if (!occ_in && !occ_out && lane_crossed[f.gate]) begin
          if (lane_dir[f.gate] == DIR_IN) begin
            r.entered = 1'b1;
            min_in_m  = (min_in_m == MIN_MAX) ? min_in_m : min_in_m + 1'b1;
            day_in_m  = (day_in_m == DAY_MAX) ? day_in_m : day_in_m + 1'b1;
          end else if (lane_dir[f.gate] == DIR_OUT) begin
            r.exited  = 1'b1;
            min_out_m = (min_out_m == MIN_MAX) ? min_out_m : min_out_m + 1'b1;
            day_out_m = (day_out_m == DAY_MAX) ? day_out_m : day_out_m + 1'b1;
          end
          if (r.entered || r.exited) begin
            lane_dir[f.gate]     = DIR_NONE;
            lane_crossed[f.gate] = 1'b0;
          end
        end
      end
    end
    // Totals after the update for a frame, before the clear for a tick.
    r.min_in  = min_in_m;
    r.min_out = min_out_m;
    r.day_in  = day_in_m;
    r.day_out = day_out_m;
    if (f.func == FN_MIN) begin
      min_in_m  = '0;
      min_out_m = '0;
    end
    if (f.func == FN_DAY) begin
      day_in_m  = '0;
      day_out_m = '0;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Shared bookkeeping between stimulus, driver and monitor.
  // ---------------------------------------------------------------------------
  frame_t      frames_pending[$];   // waiting to be offered to the block
  res_t        results_due[$];      // predicted results, oldest first
  int unsigned n_queued   = 0;
  int unsigned n_results  = 0;
  int unsigned n_entries  = 0;
  int unsigned n_exits    = 0;
  int unsigned n_rejects  = 0;
  int unsigned n_settings = 0;
  int unsigned fails      = 0;
  bit          no_idle = 1'b0;      // force full rate on both sides
  bit          hold_req = 1'b0;     // ask the receiver for one long hold-off

  // ---------------------------------------------------------------------------
  // Driver: offer frames at the falling edge, spot acceptance at the rising edge.
  // ---------------------------------------------------------------------------
  frame_t      cur_frame  = '0;
  bit          frame_taken = 1'b0;
  int unsigned send_gap  = 0;
  int unsigned send_run  = 0;
  bit          send_calm = 1'b0;

  always @(posedge clk) begin
    if (rst_n && in_push && !in_full) begin
      results_due.push_back(tally_frame(cur_frame));
      frame_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    logic push_nx;
    if (rst_n) begin
      push_nx = in_push;
      if (frame_taken) begin
        frame_taken = 1'b0;
        push_nx = 1'b0;
        // Alternate stretches of back-to-back frames with stretches of random gaps.
        if (send_run == 0) begin
          send_run  = $urandom_range(20, 80);
          send_calm = ($urandom_range(0, 2) == 0);
        end
        send_run--;
        send_gap = (no_idle || send_calm) ? 0 : $urandom_range(0, 3);
      end
      if (!push_nx) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (frames_pending.size() != 0) begin
          cur_frame = frames_pending.pop_front();
          push_nx = 1'b1;
        end
      end
      // Hold the frame steady until the block takes it.
      in_push       <= push_nx;
      in_func       <= cur_frame.func;
      in_gate       <= cur_frame.gate;
      in_left_area  <= cur_frame.left_area;
      in_right_area <= cur_frame.right_area;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare every popped result against the oldest prediction.
  // ---------------------------------------------------------------------------
  bit          result_taken = 1'b0;
  int unsigned take_gap  = 0;
  int unsigned take_run  = 0;
  bit          take_calm = 1'b0;
  int unsigned hold_left = 0;

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      if (fails < REPORT_CAP) $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_pop && !out_empty) begin
      result_taken = 1'b1;
      if (results_due.size() == 0) begin
        if (fails < REPORT_CAP) $error("result popped with no transaction outstanding");
        fails++;
      end else begin
        want = results_due.pop_front();
        check_field("status", 32'(want.status), 32'(out_status));
        check_field("entered", 32'(want.entered), 32'(out_entered));
        check_field("exited", 32'(want.exited), 32'(out_exited));
        check_field("minute_entries", 32'(want.min_in), 32'(out_minute_entries));
        check_field("minute_exits", 32'(want.min_out), 32'(out_minute_exits));
        check_field("day_entries", 32'(want.day_in), 32'(out_day_entries));
        check_field("day_exits", 32'(want.day_out), 32'(out_day_exits));
        n_results++;
        n_entries += want.entered;
        n_exits   += want.exited;
        n_rejects += want.status;
      end
    end
  end

  // Receiver pacing: per-result random stall, calm stretches, and one long hold-off.
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 48;
      end
      if (result_taken) begin
        result_taken = 1'b0;
        if (take_run == 0) begin
          take_run  = $urandom_range(20, 80);
          take_calm = ($urandom_range(0, 2) == 0);
        end
        take_run--;
        take_gap = (no_idle || take_calm) ? 0 : $urandom_range(0, 3);
      end
      if (hold_left != 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else if (take_gap != 0) begin
        take_gap--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  function automatic frame_t make(logic [FUNC_W-1:0] fn, logic [GATE_W-1:0] g,
                                  logic [AREA_W-1:0] l, logic [AREA_W-1:0] r);
    frame_t f;
    f.func       = fn;
    f.gate       = g;
    f.left_area  = l;
    f.right_area = r;
    return f;
  endfunction

  // Occupied area for the current threshold; with the threshold at its top nothing can be.
  function automatic logic [AREA_W-1:0] busy_area();
    if (thresh_m == AREA_MAX) return AREA_MAX;
    case ($urandom_range(0, 3))
      0:       return thresh_m + 1'b1;
      1:       return AREA_MAX;
      default: return AREA_W'($urandom_range(thresh_m + 1'b1, AREA_MAX));
    endcase
  endfunction

  function automatic logic [AREA_W-1:0] clear_area();
    case ($urandom_range(0, 3))
      0:       return thresh_m;
      1:       return '0;
      default: return AREA_W'($urandom_range(0, thresh_m));
    endcase
  endfunction

  function automatic logic [AREA_W-1:0] any_area();
    case ($urandom_range(0, 2))
      0:       return busy_area();
      1:       return clear_area();
      default: return AREA_W'($urandom_range(0, AREA_MAX));
    endcase
  endfunction

  // Mostly lanes in use, now and then any lane index.
  function automatic logic [GATE_W-1:0] pick_lane();
    if (gates_m == 0 || $urandom_range(0, 7) == 0) return GATE_W'($urandom_range(0, 15));
    if (gates_m >= MAX_GATES) return GATE_W'($urandom_range(0, MAX_GATES - 1));
    return GATE_W'($urandom_range(0, gates_m - 1'b1));
  endfunction

  task automatic add(frame_t f);
    frames_pending.push_back(f);
    n_queued++;
  endtask

  task automatic add_tick(logic [FUNC_W-1:0] fn);
    add(make(fn, GATE_W'($urandom_range(0, 15)), AREA_W'($urandom_range(0, AREA_MAX)),
             AREA_W'($urandom_range(0, AREA_MAX))));
  endtask

  task automatic add_one_sided(logic [GATE_W-1:0] g, bit inward);
    if (inward) add(make(FN_OBS, g, busy_area(), clear_area()));
    else        add(make(FN_OBS, g, clear_area(), busy_area()));
  endtask

  // One passage through a lane: approach, both windows, sometimes a turn, then clear.
  task automatic add_crossing(logic [GATE_W-1:0] g, bit inward);
    repeat ($urandom_range(1, 3)) add_one_sided(g, inward);
    repeat ($urandom_range(1, 2)) add(make(FN_OBS, g, busy_area(), busy_area()));
    if ($urandom_range(0, 3) == 0) add_one_sided(g, !inward);
    repeat ($urandom_range(1, 2)) add(make(FN_OBS, g, clear_area(), clear_area()));
  endtask

  task automatic add_random(int unsigned count);
    int unsigned base;
    int unsigned pick;
    base = n_queued;
    while (n_queued - base < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 65)      add_crossing(pick_lane(), 1'($urandom_range(0, 1)));
      else if (pick < 87) add(make(FN_OBS, pick_lane(), any_area(), any_area()));
      else if (pick < 93) add_tick(FN_MIN);
      else if (pick < 97) add_tick(FN_DAY);
      else                add_tick(FN_SPARE);
    end
  endtask

  // Wait until every queued frame has come back as a checked result.
  task automatic drain();
    while (n_results != n_queued) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_THRESH) thresh_m = val;
    else                   gates_m  = val[GCNT_W-1:0];
  endtask

  // Only called with the block drained, so no transaction sees a half-applied setting.
  task automatic set_config(logic [AREA_W-1:0] thresh, logic [GCNT_W-1:0] gates);
    write_reg(CFG_THRESH, thresh);
    write_reg(CFG_GATES, CFG_DATA_W'(gates));
    n_settings++;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    int k;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed frames at the reset settings (threshold 200, ten lanes).
    add(make(FN_OBS, 0, 0, 0));                     // clear lane, nothing remembered
    add(make(FN_OBS, 0, 200, 201));                 // threshold edge: outer only, exiting
    add(make(FN_OBS, 0, AREA_MAX, AREA_MAX));       // both busy
    add(make(FN_OBS, 0, 0, 0));                     // exit counted
    add(make(FN_OBS, 1, 300, 300));                 // both busy with no direction yet
    add(make(FN_OBS, 1, 0, 0));                     // clear, unknown direction: no count
    add(make(FN_OBS, 1, 201, 200));                 // inner only, crossed flag still set
    add(make(FN_OBS, 1, 0, 0));                     // entry counted from the earlier crossing
    add(make(FN_OBS, 9, 5000, 10));                 // last lane in use
    add(make(FN_OBS, 9, 5000, 5000));
    add(make(FN_OBS, 9, 201, 201));                 // both busy keeps the direction
    add(make(FN_OBS, 9, 200, 200));                 // entry counted
    add(make(FN_OBS, 10, AREA_MAX, 0));             // first rejected lane
    add(make(FN_OBS, 15, AREA_MAX, AREA_MAX));      // highest lane index, rejected
    add(make(FN_SPARE, 15, AREA_MAX, AREA_MAX));    // unused code
    add_tick(FN_MIN);
    add_tick(FN_DAY);
    add(make(FN_OBS, 2, 0, AREA_MAX));
    add(make(FN_OBS, 2, AREA_MAX, AREA_MAX));
    add(make(FN_OBS, 2, 0, 0));                     // exit after the ticks
    add_tick(FN_DAY);
    add_tick(FN_MIN);
    add_tick(FN_SPARE);
    drain();

    // Passages in both directions at full rate: three frames per passage.
    no_idle = 1'b1;
    for (k = 0; k < 50; k++) begin
      add(make(FN_OBS, GATE_W'(k % 10), AREA_MAX, 0));
      add(make(FN_OBS, GATE_W'(k % 10), AREA_MAX, AREA_MAX));
      add(make(FN_OBS, GATE_W'(k % 10), 0, 0));
    end
    for (k = 0; k < 50; k++) begin
      add(make(FN_OBS, GATE_W'(k % 10), 0, AREA_MAX));
      add(make(FN_OBS, GATE_W'(k % 10), AREA_MAX, AREA_MAX));
      add(make(FN_OBS, GATE_W'(k % 10), 0, 0));
    end
    add_tick(FN_MIN);
    add_tick(FN_DAY);
    drain();
    no_idle = 1'b0;

    // Random traffic at the reset settings, with one long receiver hold-off
    // so the internal queues fill and in_full rises.
    add_random(400);
    hold_req = 1'b1;
    drain();

    set_config('0, 5'd16);                          // lowest threshold, all lanes
    add_random(400);
    drain();

    set_config(AREA_MAX, 5'd1);                     // nothing ever occupied, one lane
    add_random(100);
    drain();

    set_config(AREA_W'($urandom_range(1, 5000)), GCNT_W'($urandom_range(1, 16)));
    add_random(400);
    drain();

    set_config(AREA_W'($urandom_range(0, 1000)), 5'd0);      // every lane rejected
    add_random(60);
    drain();

    set_config(AREA_W'($urandom_range(0, AREA_MAX)), 5'd31); // count beyond the lane array
    add_random(150);
    drain();

    set_config(AREA_W'($urandom_range(100, 2000)), 5'd16);
    add_random(300);
    drain();

    // Let any stray result surface before closing.
    repeat (20) @(negedge clk);
    $display("Checked %0d transactions over %0d register settings: %0d entries, %0d exits,",
             n_results, n_settings, n_entries, n_exits);
    $display("%0d rejected lanes, mismatches: %0d", n_rejects, fails);
    if (fails == 0) begin
      $display("tb_bidirectional_gate_passage_counter OK");
    end else begin
      $display("tb_bidirectional_gate_passage_counter NOT OK");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin
    #50_000_000;
    $display("Timed out with %0d of %0d results checked", n_results, n_queued);
    $display("tb_bidirectional_gate_passage_counter NOT OK");
    $finish;
  end

endmodule

// ----- bidirectional_gate_passage_counter.f -----
rtl/bgpc_pkg.sv
rtl/bgpc_front.sv
rtl/bgpc_back.sv
rtl/bidirectional_gate_passage_counter.sv
tb/tb_bidirectional_gate_passage_counter.sv
